// ===== hdl/cbq_pkg.sv =====
// Shared types and constants for the circular byte queue.
`timescale 1ns / 1ps
`default_nettype none
package cbq_pkg;

  // Request codes.
  localparam logic [1:0] REQ_QUERY = 2'd0;
  localparam logic [1:0] REQ_ENQ   = 2'd1;
  localparam logic [1:0] REQ_DEQ   = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Byte reported when nothing is dequeued.
  localparam logic [7:0] SPACE_CHAR = 8'd32;

  // Identity values of the min and max scan.
  localparam logic [7:0] MIN_INIT = 8'hFF;
  localparam logic [7:0] MAX_INIT = 8'h00;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] popped;
    logic       found;
    logic [7:0] min_value;
    logic [7:0] max_value;
    logic [3:0] fill;
  } rsp_t;

  // Running search result handed from cell to cell.
  typedef struct packed {
    logic       found;
    logic [7:0] min_value;
    logic [7:0] max_value;
  } acc_t;

  // Per-cell control from the queue controller.
  typedef struct packed {
    logic shift;
    logic load;
    logic live;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/cbq_stream_if.sv =====
// Valid/ready stream interface carrying one payload item.
`timescale 1ns / 1ps
`default_nettype none
interface cbq_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/circular_byte_queue_search_minmax_top.sv =====
// Top level of the circular byte queue with search and min/max report.
// An accepted item's result reaches rsp after the search result has travelled
// once along the row of DEPTH cells; no new item is accepted until that result
// is loaded into the output register, which waits while rsp is stalled.
// Reset (rst, synchronous): the queue is empty and no result is pending;
// stored bytes are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module circular_byte_queue_search_minmax_top #(
  parameter int DEPTH = 8
) (
  input wire logic clk,
  input wire logic rst,
  cbq_stream_if.sink   req,
  cbq_stream_if.source rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t                 state;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       scan_cnt;
  logic                   out_valid;
  cbq_pkg::rsp_t          rsp_q;
  logic [7:0]             key;
  logic [1:0]             op_status;
  logic [7:0]             op_popped;
  logic [CNT_W+3:0]       count_ext;

  logic                   req_fire;
  logic                   rsp_fire;
  logic                   rsp_load;
  logic                   do_enq;
  logic                   do_deq;
  logic [7:0]             cell_key;
  logic [7:0]             cell_data [DEPTH];
  cbq_pkg::acc_t          acc [DEPTH+1];
  cbq_pkg::cell_ctrl_t    ctrl [DEPTH];

  assign req_fire  = req.valid && req.ready;
  assign rsp_fire  = rsp.valid && rsp.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.payload = rsp_q;
  assign count_ext = {4'b0000, count};

  // A finished scan loads the output register once it is free or being taken.
  assign rsp_load = (state == S_SCAN) && (scan_cnt == '0) && (!out_valid || rsp.ready);

  // Successful queue operations for the accepted item.
  assign do_enq = req_fire && (req.payload.req_type == cbq_pkg::REQ_ENQ) && (count != FULL_CNT);
  assign do_deq = req_fire && (req.payload.req_type == cbq_pkg::REQ_DEQ) && (count != '0);

  // Cells load the incoming byte on acceptance and search the held key afterwards.
  assign cell_key = req_fire ? req.payload.value : key;

  // The scan enters the row with an empty result.
  assign acc[0] = '{found: 1'b0, min_value: cbq_pkg::MIN_INIT, max_value: cbq_pkg::MAX_INIT};

  // Row of cells; the oldest item sits in cell 0.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [7:0] right;

    if (i == DEPTH - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid
      assign right = cell_data[i+1];
    end

    assign ctrl[i].shift = do_deq;
    assign ctrl[i].load  = do_enq && (count == CNT_W'(i));
    assign ctrl[i].live  = (CNT_W'(i) < count);

    cbq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[i]),
      .key        (cell_key),
      .right_data (right),
      .data       (cell_data[i]),
      .acc_in     (acc[i]),
      .acc_out    (acc[i+1])
    );
  end

  // Controller: apply the operation, wait for the scan, then hand over the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      scan_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        out_valid <= 1'b1;
      end else if (rsp_fire) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            key       <= req.payload.value;
            op_status <= cbq_pkg::ST_OK;
            op_popped <= cbq_pkg::SPACE_CHAR;
            case (req.payload.req_type)
              cbq_pkg::REQ_ENQ: begin
                if (count == FULL_CNT) begin
                  op_status <= cbq_pkg::ST_FULL;
                end else begin
                  count <= count + CNT_W'(1);
                end
              end
              cbq_pkg::REQ_DEQ: begin
                if (count == '0) begin
                  op_status <= cbq_pkg::ST_EMPTY;
                end else begin
                  op_popped <= cell_data[0];
                  count     <= count - CNT_W'(1);
                end
              end
              default: begin
              end
            endcase
            scan_cnt <= FULL_CNT;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_cnt != '0) begin
            scan_cnt <= scan_cnt - CNT_W'(1);
          end else if (rsp_load) begin
            rsp_q.status    <= op_status;
            rsp_q.popped    <= op_popped;
            rsp_q.found     <= acc[DEPTH].found;
            rsp_q.min_value <= acc[DEPTH].min_value;
            rsp_q.max_value <= acc[DEPTH].max_value;
            rsp_q.fill      <= count_ext[3:0];
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The item count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue count exceeds depth");

  // A dequeue from a non-empty queue drops the count by one.
  a_deq_count: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req.payload.req_type == cbq_pkg::REQ_DEQ && count != '0)
    |=> (count == $past(count) - CNT_W'(1)))
    else $error("dequeue did not decrement count");

  // An enqueue into a full queue leaves it full and flags the rejection.
  a_enq_full: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req.payload.req_type == cbq_pkg::REQ_ENQ && count == FULL_CNT)
    |=> (count == FULL_CNT && op_status == cbq_pkg::ST_FULL))
    else $error("full enqueue not rejected");

  // A finished scan with a free output register presents its result.
  a_scan_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && scan_cnt == '0 && (!out_valid || rsp.ready))
    |=> (rsp.valid && state == S_IDLE))
    else $error("finished scan did not produce a result");

endmodule
`default_nettype wire

// ===== hdl/cbq_cell.sv =====
// One queue cell: holds a byte and folds it into the passing search result.
`timescale 1ns / 1ps
`default_nettype none
module cbq_cell (
  input  wire logic               clk,
  input  wire cbq_pkg::cell_ctrl_t ctrl,
  input  wire logic [7:0]         key,
  input  wire logic [7:0]         right_data,
  output logic [7:0]              data,
  input  wire cbq_pkg::acc_t      acc_in,
  output cbq_pkg::acc_t           acc_out
);

  cbq_pkg::acc_t acc_next;

  // Fold the held byte into the running result when it is a queued item.
  always_comb begin
    acc_next = acc_in;
    if (ctrl.live) begin
      if (data == key) begin
        acc_next.found = 1'b1;
      end
      if (data < acc_in.min_value) begin
        acc_next.min_value = data;
      end
      if (data > acc_in.max_value) begin
        acc_next.max_value = data;
      end
    end
  end

  // A dequeue moves every byte one cell toward the head; an enqueue loads the key.
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data <= right_data;
    end else if (ctrl.load) begin
      data <= key;
    end
    acc_out <= acc_next;
  end

endmodule
`default_nettype wire
